/* hw/rtl/uart_command_frame_parser_macros.svh */
// Assertion macros for the command frame parser.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef UART_COMMAND_FRAME_PARSER_MACROS_SVH
`define UART_COMMAND_FRAME_PARSER_MACROS_SVH

`ifndef SYNTH
`define CFP_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("cfp assertion failed");
`define CFP_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);
`else
`define CFP_ASSERT(lbl, clk, rstn, prop)
`define CFP_ASSERT_MSG(lbl, clk, rstn, prop, msg)
`endif

`endif

/* hw/rtl/uart_cfp_pkg.sv */
// Shared types and constants for the command frame parser.
// No dependencies.
package uart_cfp_pkg;

	localparam int unsigned FRAME_LEN = 15;
	localparam int unsigned CNT_W     = 4;

	localparam logic [CNT_W-1:0] IDX_TWO    = CNT_W'(2);
	localparam logic [CNT_W-1:0] IDX_TWELVE = CNT_W'(12);
	localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(FRAME_LEN);

	localparam logic [7:0] CH_K = 8'h4B;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_X = 8'h58;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_Q = 8'h51;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] REMOTE_MARK = 8'hFF;
	localparam logic [7:0] ZERO_MARK   = 8'h00;

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_REMOTE = 2'd1,
		MODE_ZERO   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_REMOTE   = 2'd0,
		KIND_ZERO     = 2'd1,
		KIND_INTERVAL = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		HUNT_IDLE  = 5'b00001,
		HUNT_FRAME = 5'b00010,
		HUNT_X     = 5'b00100,
		HUNT_XT    = 5'b01000,
		HUNT_XTQ   = 5'b10000
	} hunt_t;

	typedef struct packed {
		logic  reply_valid;
		kind_t reply_kind;
		logic  sending_on;
		logic  reset_request;
		logic  frame_dropped;
		mode_t mode_now;
	} cfp_result_t;

endpackage

/* hw/rtl/uart_cfp_core.sv */
// Parser state and per-byte decode for the command frame parser.
// Depends on uart_cfp_pkg and uart_command_frame_parser_macros.svh.
`include "uart_command_frame_parser_macros.svh"

module uart_cfp_core
	import uart_cfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  rx_byte,
	output cfp_result_t res
);

	hunt_t             state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
	logic [7:0]        byte_two_q, byte_twelve_q, two_eff, twelve_eff;
	mode_t             mode_q, mode_d;
	logic              send_q, send_d;

	assign cnt_inc    = cnt_q + CNT_W'(1);
	assign two_eff    = (cnt_q == IDX_TWO) ? rx_byte : byte_two_q;
	assign twelve_eff = (cnt_q == IDX_TWELVE) ? rx_byte : byte_twelve_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		mode_d  = mode_q;
		send_d  = send_q;
		res     = '{reply_valid: 1'b0, reply_kind: KIND_REMOTE, sending_on: 1'b0,
			reset_request: 1'b0, frame_dropped: 1'b0, mode_now: MODE_NONE};
		priority if (!send_q && rx_byte == CH_K) begin
			send_d = 1'b1;
		end else if (state_q == HUNT_IDLE && rx_byte == CH_S) begin
			state_d = HUNT_FRAME;
			cnt_d   = CNT_W'(1);
		end else if (state_q == HUNT_FRAME) begin
			cnt_d = cnt_inc;
			if (cnt_inc == CNT_LAST) begin
				cnt_d   = '0;
				state_d = HUNT_IDLE;
				if (rx_byte == CH_E) begin
					res.reply_valid = 1'b1;
					if (two_eff == REMOTE_MARK) begin
						mode_d         = MODE_REMOTE;
						res.reply_kind = KIND_REMOTE;
					end else if (twelve_eff == ZERO_MARK) begin
						mode_d         = MODE_ZERO;
						res.reply_kind = KIND_ZERO;
					end else begin
						res.reply_kind = KIND_INTERVAL;
					end
					if (mode_d == MODE_REMOTE)
						send_d = 1'b1;
					else if (mode_d == MODE_ZERO)
						send_d = 1'b0;
				end else begin
					res.frame_dropped = 1'b1;
				end
			end
		end else begin
			unique case (state_q)
				HUNT_IDLE: begin
					if (rx_byte == CH_X)
						state_d = HUNT_X;
				end
				HUNT_X:  state_d = (rx_byte == CH_T) ? HUNT_XT : HUNT_IDLE;
				HUNT_XT: state_d = (rx_byte == CH_Q) ? HUNT_XTQ : HUNT_IDLE;
				HUNT_XTQ: begin
					if (rx_byte == CH_D) begin
						send_d            = 1'b0;
						res.reset_request = 1'b1;
					end
					state_d = HUNT_IDLE;
				end
				default: state_d = HUNT_IDLE;
			endcase
		end
		res.sending_on = send_d;
		res.mode_now   = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HUNT_IDLE;
			cnt_q   <= '0;
			mode_q  <= MODE_NONE;
			send_q  <= 1'b0;
		end else if (fire) begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			mode_q  <= mode_d;
			send_q  <= send_d;
		end
	end

	// frame bytes kept without reset; always written before the frame end
	always_ff @(posedge clk) begin
		if (fire && state_q == HUNT_FRAME && cnt_q == IDX_TWO)
			byte_two_q <= rx_byte;
		if (fire && state_q == HUNT_FRAME && cnt_q == IDX_TWELVE)
			byte_twelve_q <= rx_byte;
	end

	`CFP_ASSERT(a_reply_excl, clk, arst_n,
		fire |-> !(res.reply_valid && (res.reset_request || res.frame_dropped)))
	`CFP_ASSERT(a_remote_sends, clk, arst_n,
		(fire && res.reply_valid && res.reply_kind == KIND_REMOTE) |-> res.sending_on)
	`CFP_ASSERT_MSG(a_reset_mutes, clk, arst_n,
		(fire && res.reset_request) |=> !send_q, "reset request left sending on")
	`CFP_ASSERT_MSG(a_cnt_in_frame, clk, arst_n,
		(cnt_q != '0) |-> (state_q == HUNT_FRAME), "byte count outside a frame")

endmodule

/* hw/rtl/uart_command_frame_parser.sv */
// Top level of the serial command frame parser: input stage, result register.
// Depends on uart_cfp_pkg and uart_cfp_core.
//
// Usage:
//   s_axis carries one received serial byte per transfer in s_tdata[7:0].
//   m_axis returns exactly one result per accepted byte, in order:
//     reply flag and kind, sending state, reset request, dropped frame flag
//     and current mode after that byte.
// Path: an accepted byte is held in the input register, then decoded into the
//   result register when that register is empty or m_tready is high.
// Throughput: one byte per cycle while m_tready is high; the parser state update is
//   combinational compare logic in the decode stage.
// Reset: arst_n clears both stages, the hunt state, byte count, mode
//   and sending flag; the two kept frame bytes are not reset.
// Stall: while m_tready is low and a result waits, the decode stage holds;
//   s_tready falls once the input register is also occupied, and nothing
//   is lost or repeated.
module uart_command_frame_parser
	import uart_cfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] reply_valid, [2:1] reply_kind, [3] sending_on,
	                              // [4] reset_request, [5] frame_dropped, [7:6] mode_now
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;
	logic        fire;
	cfp_result_t res;
	cfp_result_t res_s2;
	logic        valid_s2;

	assign adv      = !valid_s2 || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = adv || !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
		if (fire)
			res_s2 <= res;
	end

	uart_cfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (byte_s1),
		.res     (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.mode_now, res_s2.frame_dropped, res_s2.reset_request,
		res_s2.sending_on, res_s2.reply_kind, res_s2.reply_valid};

endmodule
